FILE: sv/mmfca_pkg.sv
// ============================================================================
// mmfca_pkg
// Types, check type codes and per-byte update functions for the multi-mode
// frame check accumulator.
// ============================================================================
`default_nettype none

package mmfca_pkg;

    // Command codes.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_ADD   = 1'b1;

    // Check type codes.
    localparam logic [2:0] CT_NONE       = 3'd0;
    localparam logic [2:0] CT_RETRANSMIT = 3'd1;
    localparam logic [2:0] CT_SUM8       = 3'd2;
    localparam logic [2:0] CT_CRC8       = 3'd3;
    localparam logic [2:0] CT_CRC16      = 3'd4;
    localparam logic [2:0] CT_CRC32      = 3'd5;
    localparam logic [2:0] CT_FEC        = 3'd6;
    localparam logic [2:0] CT_USER       = 3'd7;

    localparam logic [7:0]  CRC8_TAP   = 8'h18;
    localparam logic [15:0] CRC16_POLY = 16'h1021;
    localparam logic [31:0] CRC32_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC32_INIT = 32'hFFFF_FFFF;

    typedef struct packed {
        logic       command;
        logic [2:0] check_type;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [31:0] check_value;
        logic        type_supported;
    } result_t;

    function automatic logic type_is_supported(input logic [2:0] t);
        return (t == CT_NONE) || (t == CT_SUM8) || (t == CT_CRC8) ||
               (t == CT_CRC16) || (t == CT_CRC32);
    endfunction

    // Reflected Dallas/Maxim CRC-8, one byte, LSB first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] v_in);
        logic [7:0] crc;
        logic [7:0] v;
        logic       fb;
        crc = crc_in;
        v   = v_in;
        for (int k = 0; k < 8; k++) begin
            fb = crc[0] ^ v[0];
            if (fb) begin
                crc = crc ^ CRC8_TAP;
            end
            crc = {fb, crc[7:1]};
            v   = {1'b0, v[7:1]};
        end
        return crc;
    endfunction

    // CRC-16, polynomial 0x1021, MSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  v);
        logic [15:0] crc;
        crc = crc_in ^ {v, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC16_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

    // Reflected CRC-32, one byte, LSB first.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  v);
        logic [31:0] crc;
        crc = crc_in ^ {24'h000000, v};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = {1'b0, crc[31:1]} ^ CRC32_POLY;
            end else begin
                crc = {1'b0, crc[31:1]};
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

FILE: sv/multi_mode_frame_check_accumulator_unit.sv
// ============================================================================
// multi_mode_frame_check_accumulator_unit
// Per-packet checksum / CRC accumulator with selectable check type.
// ============================================================================
// Usage:
// Items arrive on the item channel (item_valid, item_ready, item). Each item
// is either a start, which initializes the shared accumulator for the type
// it carries, or a data byte, which is folded into the accumulator with the
// algorithm of its type. Every item yields exactly one result on the result
// channel (result_valid, result_ready, result): the check value after that
// item and a flag telling whether the type is supported.
// An accepted item is held in the input register; when it moves on, the
// update logic writes the accumulator and the result register together.
// Throughput is one item per cycle while result_ready stays high; the
// byte-wide CRC update is unrolled, so the accumulator feedback is
// combinational.
// When the receiver stalls, the result register holds its item and the
// input register can still take one more item; after that item_ready drops
// until result_ready returns. Reset clears the accumulator to zero and
// empties both registers.
// ============================================================================
`default_nettype none

module multi_mode_frame_check_accumulator_unit
    import mmfca_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_ready,
    input  wire item_t   item,
    output logic         result_valid,
    input  wire logic    result_ready,
    output result_t      result
);

    // Input register stage.
    logic        stage_valid_reg;
    item_t       stage_reg;

    // Running accumulator and result register.
    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic        out_valid_reg;
    result_t     out_reg;
    result_t     out_next;

    logic        advance;
    logic        supported;

    // The staged item moves on when the result register is empty or is
    // being emptied in this cycle.
    assign advance    = stage_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !stage_valid_reg || advance;

    assign supported  = type_is_supported(stage_reg.check_type);

    // Accumulator update for the staged item.
    always_comb
    begin
        acc_next = acc_reg;
        if (stage_reg.command == CMD_START) begin
            if (stage_reg.check_type == CT_CRC32) begin
                acc_next = CRC32_INIT;
            end else if (supported) begin
                acc_next = '0;
            end
        end else begin
            case (stage_reg.check_type)
                CT_SUM8:
                begin
                    acc_next[7:0] = acc_reg[7:0] + stage_reg.data_byte;
                end
                CT_CRC8:
                begin
                    acc_next[7:0] = crc8_byte(acc_reg[7:0], stage_reg.data_byte);
                end
                CT_CRC16:
                begin
                    acc_next[15:0] = crc16_byte(acc_reg[15:0], stage_reg.data_byte);
                end
                CT_CRC32:
                begin
                    acc_next = crc32_byte(acc_reg, stage_reg.data_byte);
                end
                default:
                begin
                    // None and unsupported types leave the accumulator alone.
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    // Reported value, taken from the updated accumulator.
    always_comb
    begin
        out_next.type_supported = supported;
        case (stage_reg.check_type)
            CT_SUM8, CT_CRC8:
            begin
                out_next.check_value = {24'h000000, acc_next[7:0]};
            end
            CT_CRC16:
            begin
                out_next.check_value = {16'h0000, acc_next[15:0]};
            end
            CT_CRC32:
            begin
                out_next.check_value = ~acc_next;
            end
            default:
            begin
                out_next.check_value = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            acc_reg         <= '0;
        end else begin
            if (item_ready) begin
                stage_valid_reg <= item_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                acc_reg       <= acc_next;
            end else if (result_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid) begin
            stage_reg <= item;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Assertions.
    a_unsupported_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.type_supported) |-> (out_reg.check_value == '0))
        else $error("unsupported type reported a nonzero check value");

    a_unsupported_keeps_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !supported) |=> $stable(acc_reg))
        else $error("unsupported type changed the accumulator");

    a_crc32_start: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && stage_reg.command == CMD_START && stage_reg.check_type == CT_CRC32)
        |=> (acc_reg == CRC32_INIT))
        else $error("crc32 start did not preset the accumulator");

    a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !stage_valid_reg |-> item_ready)
        else $error("empty input stage refused an item");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_ready) |-> !advance)
        else $error("stalled result was overwritten");

endmodule

`default_nettype wire
